/* src/quaternion_multiply_normalize_macros.svh */
// Assertion macros shared by the quaternion multiply and normalize block.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QMN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QMN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/qmn_pkg.sv */
// Shared types and widths of the quaternion multiply and normalize block.
package qmn_pkg;

   localparam int CompW      = 16;
   localparam int ProdW      = 34;
   localparam int AbsW       = 33;
   localparam int MagW       = 31;
   localparam int SqW        = 62;
   localparam int SumW       = 64;
   localparam int RootW      = 32;
   localparam int RemW       = 34;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = 2;
   localparam int QCntW      = 3;

   typedef struct packed {
      logic [3:0][MagW-1:0] mag;
      logic [3:0]           neg;
      logic                 zero;
   } qmn_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } qmn_queue_ctl_type;

endpackage

/* src/qmn_front.sv */
// Front part: input register, Hamilton product and sign/magnitude classification.
module qmn_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [127:0]          req_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   input  logic                  full,
   output qmn_pkg::qmn_queue_ctl_type ctl,
   output qmn_pkg::qmn_item_type push_item
);

   logic                               fen;
   logic                               fa_valid_ff;
   logic [127:0]                       fa_data_ff;
   logic                               fb_valid_ff;
   logic signed [31:0]                 prod_ff [4][4];
   logic signed [qmn_pkg::CompW-1:0]   a [4];
   logic signed [qmn_pkg::CompW-1:0]   b [4];
   logic signed [qmn_pkg::ProdW-1:0]   pe [4][4];
   logic signed [qmn_pkg::ProdW-1:0]   p [4];
   logic [qmn_pkg::AbsW-1:0]           abs_v [4];
   logic                               big;

   assign fen        = !(fb_valid_ff && full);
   assign req_tready = fen;
   assign ctl.push   = fb_valid_ff && !full;
   assign ctl.full   = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_valid_ff <= 1'b0;
         fb_valid_ff <= 1'b0;
      end else if (fen) begin
         fa_valid_ff <= req_tvalid;
         fb_valid_ff <= fa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         fa_data_ff <= req_tdata;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_op
      assign a[i] = fa_data_ff[16*i +: 16];
      assign b[i] = fa_data_ff[64 + 16*i +: 16];
      for (genvar j = 0; j < 4; j++) begin : g_mul
         always_ff @(posedge clock) begin
            if (fen) begin
               prod_ff[i][j] <= 32'(a[i]) * 32'(b[j]);
            end
         end
         assign pe[i][j] = qmn_pkg::ProdW'(prod_ff[i][j]);
      end
   end

   assign p[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
   assign p[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
   assign p[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
   assign p[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];

   for (genvar i = 0; i < 4; i++) begin : g_abs
      assign abs_v[i] = p[i][qmn_pkg::ProdW-1] ? qmn_pkg::AbsW'(-p[i])
                                                : qmn_pkg::AbsW'(p[i]);
      assign push_item.neg[i] = p[i][qmn_pkg::ProdW-1];
      assign push_item.mag[i] = big ? qmn_pkg::MagW'(abs_v[i] >> 2)
                                    : abs_v[i][qmn_pkg::MagW-1:0];
   end

   assign big = (|abs_v[0][32:31]) || (|abs_v[1][32:31]) ||
                (|abs_v[2][32:31]) || (|abs_v[3][32:31]);
   assign push_item.zero = (p[0] == '0) && (p[1] == '0) && (p[2] == '0) && (p[3] == '0);

endmodule

/* src/qmn_fifo.sv */
// Short queue between the front and back parts.
`include "quaternion_multiply_normalize_macros.svh"
module qmn_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  qmn_pkg::qmn_queue_ctl_type ctl,
   input  qmn_pkg::qmn_item_type push_item,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output qmn_pkg::qmn_item_type pop_item
);

   qmn_pkg::qmn_item_type          mem_ff [qmn_pkg::QueueDepth];
   logic [qmn_pkg::QPtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [qmn_pkg::QPtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [qmn_pkg::QCntW-1:0]      count_ff, count_in;

   assign full     = (count_ff == qmn_pkg::QCntW'(qmn_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = ctl.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + qmn_pkg::QCntW'(ctl.push) - qmn_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `QMN_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= qmn_pkg::QCntW'(qmn_pkg::QueueDepth), "queue count exceeds depth")
   `QMN_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty, "queue popped while empty")
   `QMN_ASSERT_NOW(a_no_overflow, clock, reset, ctl.push, !full, "queue pushed while full")

endmodule

/* src/qmn_back.sv */
// Back part: squares, square root and division pipeline with saturation and output register.
module qmn_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  qmn_pkg::qmn_item_type pop_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,  // r_w, r_x, r_y, r_z
   output logic [0:0]            rsp_tuser   // zero_norm
);

   localparam int QB = FRAC_BITS + 1;
   localparam int DW = qmn_pkg::MagW + FRAC_BITS + 1;
   localparam int RW = qmn_pkg::RootW + 1;
   localparam int NS = qmn_pkg::RootW;

   logic adv;
   logic out_valid_ff;
   logic [63:0] out_data_ff;
   logic out_zero_ff;

   logic                          s1_valid_ff;
   qmn_pkg::qmn_item_type         s1_item_ff;
   logic [qmn_pkg::SqW-1:0]       s1_sq_ff [4];

   logic                          sq_valid_ff [NS+1];
   qmn_pkg::qmn_item_type         sq_item_ff  [NS+1];
   logic [qmn_pkg::SumW-1:0]      sq_s_ff     [NS+1];
   logic [qmn_pkg::RootW-1:0]     sq_root_ff  [NS+1];
   logic [qmn_pkg::RemW-1:0]      sq_rem_ff   [NS+1];

   logic [DW-1:0]                 dvd         [4];
   logic                          dv_valid_ff [QB+1];
   logic [3:0]                    dv_neg_ff   [QB+1];
   logic                          dv_zero_ff  [QB+1];
   logic [qmn_pkg::RootW-1:0]     dv_n_ff     [QB+1];
   logic [DW-1:0]                 dv_d_ff     [QB+1][4];
   logic [RW-1:0]                 dv_r_ff     [QB+1][4];
   logic [QB-1:0]                 dv_q_ff     [QB+1][4];

   logic [15:0]                   res [4];

   assign adv        = !out_valid_ff || rsp_tready;
   assign pop        = adv && !empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= !empty;
         sq_valid_ff[0] <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= pop_item;
         for (int l = 0; l < 4; l++) begin
            s1_sq_ff[l] <= qmn_pkg::SqW'(pop_item.mag[l]) * qmn_pkg::SqW'(pop_item.mag[l]);
         end
         sq_item_ff[0] <= s1_item_ff;
         sq_s_ff[0]    <= qmn_pkg::SumW'(s1_sq_ff[0]) + qmn_pkg::SumW'(s1_sq_ff[1]) +
                          qmn_pkg::SumW'(s1_sq_ff[2]) + qmn_pkg::SumW'(s1_sq_ff[3]);
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [qmn_pkg::RemW-1:0]  remx;
      logic [qmn_pkg::RemW-1:0]  trial;
      logic                      ge;

      assign remx  = {sq_rem_ff[k][qmn_pkg::RemW-3:0],
                      sq_s_ff[k][qmn_pkg::SumW-1-2*k -: 2]};
      assign trial = {sq_root_ff[k], 2'b01};
      assign ge    = (remx >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_item_ff[k+1] <= sq_item_ff[k];
            sq_s_ff[k+1]    <= sq_s_ff[k];
            sq_rem_ff[k+1]  <= ge ? remx - trial : remx;
            sq_root_ff[k+1] <= {sq_root_ff[k][qmn_pkg::RootW-2:0], ge};
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_dvd
      assign dvd[l] = {1'b0, sq_item_ff[NS].mag[l], FRAC_BITS'(0)} +
                      DW'(sq_root_ff[NS] >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= sq_valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_neg_ff[0]  <= sq_item_ff[NS].neg;
         dv_zero_ff[0] <= sq_item_ff[NS].zero;
         dv_n_ff[0]    <= sq_root_ff[NS];
         for (int l = 0; l < 4; l++) begin
            dv_d_ff[0][l] <= dvd[l];
            dv_r_ff[0][l] <= RW'(dvd[l][DW-1:QB]);
            dv_q_ff[0][l] <= '0;
         end
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_n_ff[j+1]    <= dv_n_ff[j];
         end
      end

      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic [RW-1:0] rx;
         logic          ge;

         assign rx = {dv_r_ff[j][l][RW-2:0], dv_d_ff[j][l][QB-1-j]};
         assign ge = (rx >= {1'b0, dv_n_ff[j]});

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_d_ff[j+1][l] <= dv_d_ff[j][l];
               dv_r_ff[j+1][l] <= ge ? rx - {1'b0, dv_n_ff[j]} : rx;
               dv_q_ff[j+1][l] <= {dv_q_ff[j][l][QB-2:0], ge};
            end
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_sat
      logic [31:0] qe;

      assign qe = 32'(dv_q_ff[QB][l]);

      always_comb begin
         if (dv_zero_ff[QB]) begin
            res[l] = '0;
         end else if (dv_neg_ff[QB][l]) begin
            res[l] = (qe > 32'd32768) ? 16'h8000 : 16'(-qe);
         end else begin
            res[l] = (qe > 32'd32767) ? 16'h7FFF : qe[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {res[3], res[2], res[1], res[0]};
         out_zero_ff <= dv_zero_ff[QB];
      end
   end

endmodule

/* src/quaternion_multiply_normalize.sv */
// Top level of the normalized Hamilton quaternion product.
// The block accepts one pair of quaternions per cycle while req_tready is high and returns one
// unit quaternion per transfer in Q2.FRAC_BITS, with zero_norm set and all components zero
// when the product is zero. The pipeline holds two front stages for the products, the queue,
// two stages for squares and their sum, 32 stages of the digit-by-digit square root, one
// stage to set up the dividends, FRAC_BITS + 1 stages of the four parallel restoring
// dividers, and the output register. The four-entry queue lets the front keep taking
// transfers while the back pipeline waits on rsp_tready.
`include "quaternion_multiply_normalize_macros.svh"
module quaternion_multiply_normalize #(
   parameter int FRAC_BITS = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // r_w, r_x, r_y, r_z
   output logic [0:0]   rsp_tuser   // zero_norm
);

   qmn_pkg::qmn_queue_ctl_type ctl;
   qmn_pkg::qmn_item_type      push_item;
   qmn_pkg::qmn_item_type      pop_item;
   logic                       full;
   logic                       empty;
   logic                       pop;

   qmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .full       (full),
      .ctl        (ctl),
      .push_item  (push_item)
   );

   qmn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .push_item (push_item),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .pop_item  (pop_item)
   );

   qmn_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `QMN_ASSERT_NOW(a_zero_clears, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "zero norm result carries nonzero data")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the normalized Hamilton quaternion product block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS   = 14;
   localparam int LATENCY     = FRAC_BITS + 40;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [15:0] r_w;
      logic [15:0] r_x;
      logic [15:0] r_y;
      logic [15:0] r_z;
      logic        zero_norm;
   } unit_quat_type;

   typedef struct {
      logic [127:0]  data;
      logic          known;
      unit_quat_type result;
   } vector_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   unit_quat_type expected_products[$];
   vector_type    vectors[$];
   int            errors;
   int            cycles;
   logic          steady;

   quaternion_multiply_normalize #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] value);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > value) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (value >= root + bitv) begin
            value = value - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic unit_quat_type normalized_product(logic [127:0] data);
      longint a[4];
      longint b[4];
      longint p[4];
      logic [63:0] mag[4];
      logic neg[4];
      logic [63:0] maxm;
      logic [63:0] sum;
      logic [63:0] norm;
      logic [63:0] q;
      logic [15:0] comp[4];
      unit_quat_type res;
      for (int i = 0; i < 4; i++) begin
         a[i] = longint'($signed(data[16*i +: 16]));
         b[i] = longint'($signed(data[64 + 16*i +: 16]));
      end
      p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
      maxm = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = p[i] < 0;
         mag[i] = neg[i] ? -p[i] : p[i];
         if (mag[i] > maxm) maxm = mag[i];
      end
      res = '0;
      if (maxm == 0) begin
         res.zero_norm = 1'b1;
         return res;
      end
      if (maxm >= (64'd1 << 31)) begin
         for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 2;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
      norm = int_sqrt(sum);
      if (norm == 0) norm = 1;
      for (int i = 0; i < 4; i++) begin
         q = ((mag[i] << FRAC_BITS) + (norm >> 1)) / norm;
         if (neg[i]) begin
            if (q > 32768) q = 32768;
            comp[i] = 16'(-q);
         end else begin
            if (q > 32767) q = 32767;
            comp[i] = q[15:0];
         end
      end
      res.r_w = comp[0];
      res.r_x = comp[1];
      res.r_y = comp[2];
      res.r_z = comp[3];
      return res;
   endfunction

   function automatic logic [127:0] pack_pair(logic [15:0] aw, logic [15:0] ax, logic [15:0] ay,
                                             logic [15:0] az, logic [15:0] bw, logic [15:0] bx,
                                             logic [15:0] by, logic [15:0] bz);
      return {bz, by, bx, bw, az, ay, ax, aw};
   endfunction

   function automatic logic idle_now();
      return !steady && ($urandom_range(99) < 35);
   endfunction

   task automatic add_row(logic [127:0] data, logic known, unit_quat_type result);
      vector_type v;
      v.data = data;
      v.known = known;
      v.result = result;
      vectors.push_back(v);
   endtask

   task automatic send_pair(logic [127:0] data);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Directed table: only a few rows carry a result readable at a glance.
   task automatic build_table();
      add_row(pack_pair(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0), 1'b1, {16'h4000, 48'h0, 1'b0});
      add_row('0, 1'b1, {64'h0, 1'b1});
      add_row(pack_pair(16'h4000, 0, 0, 0, 0, 0, 0, 0), 1'b1, {64'h0, 1'b1});
      add_row(pack_pair(0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0), 1'b1, {16'hC000, 48'h0, 1'b0});
      add_row(pack_pair(0, 0, 16'h4000, 0, 0, 0, 16'h4000, 0), 1'b1, {16'hC000, 48'h0, 1'b0});
      add_row(pack_pair(0, 0, 0, 16'h4000, 0, 0, 0, 16'h4000), 1'b1, {16'hC000, 48'h0, 1'b0});
      add_row(pack_pair(0, 16'h4000, 0, 0, 0, 0, 16'h4000, 0), 1'b1,
              {16'h0, 16'h0, 16'h0, 16'h4000, 1'b0});
      add_row(pack_pair(0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1, {64'h0, 1'b1});
      add_row({8{16'h8000}}, 1'b0, '0);
      add_row({8{16'h7FFF}}, 1'b0, '0);
      add_row({8{16'hFFFF}}, 1'b0, '0);
      add_row({8{16'h0001}}, 1'b0, '0);
      add_row({64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF}, 1'b0, '0);
      add_row({64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF}, 1'b0, '0);
      add_row(pack_pair(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0), 1'b0, '0);
      add_row(pack_pair(16'h7FFF, 16'h7FFF, 0, 0, 16'h7FFF, 16'h8001, 0, 0), 1'b0, '0);
      add_row(pack_pair(16'h2D41, 16'h2D41, 0, 0, 16'h2D41, 0, 16'h2D41, 0), 1'b0, '0);
      add_row(pack_pair(1, 0, 0, 0, 1, 1, 1, 1), 1'b0, '0);
      add_row(pack_pair(1, 0, 0, 0, 16'hFFFF, 0, 0, 0), 1'b0, '0);
   endtask

   function automatic logic [15:0] random_comp();
      case ($urandom_range(5))
         0: return 16'h8000 + 16'($urandom_range(3));
         1: return 16'h7FFF - 16'($urandom_range(3));
         2: return 16'($signed(6'($urandom)));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      vector_type v;
      logic [127:0] data;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      reset      = 1'b1;
      steady     = 1'b0;
      errors     = 0;
      build_table();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (vectors[i]) begin
         v = vectors[i];
         if (v.known && normalized_product(v.data) != v.result) begin
            $error("table row %0d disagrees with predictor", i);
            errors++;
         end
         expected_products.push_back(v.known ? v.result : normalized_product(v.data));
         send_pair(v.data);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 250);
         for (int i = 0; i < 8; i++) data[16*i +: 16] = random_comp();
         if ($urandom_range(19) == 0) data[63:0] = '0;
         expected_products.push_back(normalized_product(data));
         send_pair(data);
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      unit_quat_type want;
      cycles <= reset ? 0 : cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_products.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = expected_products.pop_front();
            if (rsp_tdata[15:0] !== want.r_w) begin
               $error("r_w expected %h actual %h", want.r_w, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== want.r_x) begin
               $error("r_x expected %h actual %h", want.r_x, rsp_tdata[31:16]);
               errors++;
            end
            if (rsp_tdata[47:32] !== want.r_y) begin
               $error("r_y expected %h actual %h", want.r_y, rsp_tdata[47:32]);
               errors++;
            end
            if (rsp_tdata[63:48] !== want.r_z) begin
               $error("r_z expected %h actual %h", want.r_z, rsp_tdata[63:48]);
               errors++;
            end
            if (rsp_tuser[0] !== want.zero_norm) begin
               $error("zero_norm expected %b actual %b", want.zero_norm, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

endmodule
